// File: hw/rtl/sgrg_pkg.sv
// ----------------------------------------------------------------------------
// sgrg_pkg: shared types, constants and font tables
// Holds the 5x8 glyph tables (ASCII and Cyrillic) and the code classifier
// used by the front end of the scaled glyph row generator.
// ----------------------------------------------------------------------------
package sgrg_pkg;

	localparam int GLYPH_COLUMNS = 5;
	localparam int CELL_ROWS     = 8;
	localparam int FONT_ROW_W    = 3;
	localparam int CODE_W        = 8;
	localparam int ROW_NUMBER_W  = 5;
	localparam int ROW_PIXELS_W  = 24;
	localparam int TDATA_W       = 32;
	localparam int COLOR_W       = 16;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int SCALE_REG_W   = 3;
	localparam int QUEUE_DEPTH   = 2;
	localparam int LATIN_COUNT   = 95;
	localparam int CYR_COUNT     = 66;
	localparam int FONT_IDX_W    = 7;

	// code ranges
	localparam logic [CODE_W-1:0] ASCII_FIRST  = 8'h20;
	localparam logic [CODE_W-1:0] ASCII_LAST   = 8'h7E;
	localparam logic [CODE_W-1:0] CYR_A_FIRST  = 8'h80;
	localparam logic [CODE_W-1:0] CYR_A_LAST   = 8'hAF;
	localparam logic [CODE_W-1:0] CYR_B_FIRST  = 8'hE0;
	localparam logic [CODE_W-1:0] CYR_B_LAST   = 8'hF1;
	localparam logic [CODE_W-1:0] CYR_B_OFFSET = 8'hB0;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE    = 2'd2;

	// column 0 is the leftmost byte of each literal
	typedef logic [0:GLYPH_COLUMNS-1][7:0] font_glyph_t;

	typedef struct packed {
		font_glyph_t cols;
		logic        no_glyph;
	} glyph_t;

	localparam font_glyph_t LATIN_FONT [0:LATIN_COUNT-1] = '{
		40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
		40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
		40'h14083e0814, 40'h08083e0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
		40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
		40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324979413e, 40'h7e1111117e, 40'h7f49494936,
		40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
		40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
		40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
		40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
		40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
		40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
		40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
		40'h087e090102, 40'h0c5252523e, 40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
		40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
		40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
		40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
		40'h4464544c44, 40'h0008364100, 40'h00007f0000, 40'h0041360800, 40'h1008081008
	};

	localparam font_glyph_t CYR_FONT [0:CYR_COUNT-1] = '{
		40'h7e1111117e, 40'h7f49494933, 40'h7f49494936, 40'h7f01010103, 40'he0514f41ff,
		40'h7f49494941, 40'h77087f0877, 40'h4149494936, 40'h7f1008047f, 40'h7c2112097c,
		40'h7f08142241, 40'h20413f017f, 40'h7f020c027f, 40'h7f0808087f, 40'h3e4141413e,
		40'h7f0101017f, 40'h7f09090906, 40'h3e41414122, 40'h01017f0101, 40'h4728100807,
		40'h1c227f221c, 40'h6314081463, 40'h7f404040ff, 40'h070808087f, 40'h7f407f407f,
		40'h7f407f40ff, 40'h017f484830, 40'h7f4830007f, 40'h007f484830, 40'h224149493e,
		40'h7f083e413e, 40'h462919097f, 40'h2054545478, 40'h3c4a4a4931, 40'h7c54542800,
		40'h7c0404040c, 40'he0544c44fc, 40'h3854545418, 40'h6c107c106c, 40'h4444545428,
		40'h7c2010087c, 40'h7c4122117c, 40'h7c10284400, 40'h20443c047c, 40'h7c0810087c,
		40'h7c1010107c, 40'h3844444438, 40'h7c0404047c, 40'h7c14141408, 40'h3844444420,
		40'h04047c0404, 40'h0c5050503c, 40'h3048fc4830, 40'h4428102844, 40'h7c404040fc,
		40'h0c1010107c, 40'h7c407c407c, 40'h7c407c40fc, 40'h047c505020, 40'h7c5050207c,
		40'h7c50502000, 40'h2844545438, 40'h7c10384438, 40'h085434147c, 40'h7c55545544,
		40'h3855545518
	};

	// classify a code and fetch its glyph columns
	function automatic glyph_t glyph_lookup(input logic [CODE_W-1:0] code);
		glyph_t g;
		g.cols     = '0;
		g.no_glyph = 1'b0;
		if (code >= ASCII_FIRST && code <= ASCII_LAST) begin
			g.cols = LATIN_FONT[FONT_IDX_W'(code - ASCII_FIRST)];
		end else if (code >= CYR_A_FIRST && code <= CYR_A_LAST) begin
			g.cols = CYR_FONT[FONT_IDX_W'(code - CYR_A_FIRST)];
		end else if (code >= CYR_B_FIRST && code <= CYR_B_LAST) begin
			g.cols = CYR_FONT[FONT_IDX_W'(code - CYR_B_OFFSET)];
		end else begin
			g.no_glyph = 1'b1;
		end
		return g;
	endfunction

endpackage

// File: hw/rtl/scaled_glyph_row_generator.sv
// ----------------------------------------------------------------------------
// scaled_glyph_row_generator: magnified 5x8 character row generator
// Turns character codes into pixel-mask rows of a scaled character cell.
// ----------------------------------------------------------------------------
// Each accepted character code produces 8*scale rows (8 to 32 at the default
// MAX_SCALE of 4), one row per clock while the output is taken. A code passes
// the front stage register and the glyph queue before the back end registers
// its first row on the output. Codes are fetched and classified ahead of time
// and wait in a two-entry queue, so the input keeps accepting while rows
// still stream out.
// Row bit i is pixel column i from the left; the last scale columns of each
// row are the clear spacing column. Codes with no glyph give blank rows with
// the tuser flag set. Write configuration only while no item is in flight;
// a scale of 0 acts as 1 and a scale above MAX_SCALE acts as MAX_SCALE.
// ----------------------------------------------------------------------------
module scaled_glyph_row_generator #(
	parameter int MAX_SCALE = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// code input
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sgrg_pkg::CODE_W-1:0]         s_tdata,   // [7:0] char_code
	// row output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sgrg_pkg::TDATA_W-1:0]        m_tdata,   // [4:0] row_number,
	                                                       // [28:5] row_pixels,
	                                                       // [31:29] zero
	output logic                                m_tlast,
	output logic                                m_tuser,   // [0] no_glyph
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sgrg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sgrg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int SC_W = $clog2(MAX_SCALE + 1);

	logic [sgrg_pkg::COLOR_W-1:0]      fg_color_q;
	logic [sgrg_pkg::COLOR_W-1:0]      bg_color_q;
	logic [sgrg_pkg::SCALE_REG_W-1:0]  scale_q;
	logic [SC_W-1:0]                   scale_eff;
	logic                              push_valid;
	logic                              push_ready;
	sgrg_pkg::glyph_t                  push_item;
	logic                              head_valid;
	logic                              head_ready;
	sgrg_pkg::glyph_t                  head_item;
	logic [sgrg_pkg::ROW_NUMBER_W-1:0] row_number;
	logic [sgrg_pkg::ROW_PIXELS_W-1:0] row_pixels;

	assign cfg_ready = 1'b1;

	// configuration registers; the colors are held but not used by the row path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q <= 16'hFFFF;
			bg_color_q <= 16'h0000;
			scale_q    <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sgrg_pkg::REG_FG_COLOR: fg_color_q <= cfg_data;
				sgrg_pkg::REG_BG_COLOR: bg_color_q <= cfg_data;
				sgrg_pkg::REG_SCALE:    scale_q    <= cfg_data[sgrg_pkg::SCALE_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp scale into 1..MAX_SCALE
	always_comb begin
		if (scale_q == '0) begin
			scale_eff = SC_W'(1);
		end else if (int'(scale_q) > MAX_SCALE) begin
			scale_eff = SC_W'(MAX_SCALE);
		end else begin
			scale_eff = SC_W'(scale_q);
		end
	end

	sgrg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_code    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	sgrg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_item   (head_item)
	);

	sgrg_back #(
		.MAX_SCALE (MAX_SCALE),
		.SC_W      (SC_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.scale        (scale_eff),
		.head_valid   (head_valid),
		.head_ready   (head_ready),
		.head_item    (head_item),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_row      (row_number),
		.out_pixels   (row_pixels),
		.out_last     (m_tlast),
		.out_no_glyph (m_tuser)
	);

	// pack output item
	assign m_tdata = {3'b000, row_pixels, row_number};

`ifndef SYNTHESIS
	// a new character starts at row zero
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || m_tdata[4:0] == 5'd0))
		else $error("row after last row is not row zero");

	// rows of one character follow back to back in order
	a_row_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(m_tvalid && m_tdata[4:0] == $past(m_tdata[4:0]) + 5'd1))
		else $error("row sequence broken inside a character");

	// no pixels beyond the scaled cell width
	a_cell_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[28:5] >> (6 * int'(scale_eff))) == 24'd0))
		else $error("pixel set outside the cell");

	// blank rows for codes without a glyph
	a_blank_row: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[28:5] == 24'd0))
		else $error("pixels set on a code without glyph");
`endif

endmodule

// File: hw/rtl/sgrg_front.sv
// ----------------------------------------------------------------------------
// sgrg_front: code intake and glyph fetch
// Accepts character codes, classifies them and registers the glyph columns
// together with the no-glyph flag for the row queue.
// ----------------------------------------------------------------------------
module sgrg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sgrg_pkg::CODE_W-1:0]   in_code,
	output logic                          push_valid,
	input  logic                          push_ready,
	output sgrg_pkg::glyph_t              push_item
);

	logic             valid_s1;
	sgrg_pkg::glyph_t item_s1;

	// take a new item whenever the stage is empty or drains this cycle
	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// glyph payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= sgrg_pkg::glyph_lookup(in_code);
		end
	end

endmodule

// File: hw/rtl/sgrg_queue.sv
// ----------------------------------------------------------------------------
// sgrg_queue: glyph queue between front and back
// Short first-in first-out buffer of fetched glyphs so the intake and the
// row emitter stall independently.
// ----------------------------------------------------------------------------
module sgrg_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  sgrg_pkg::glyph_t push_item,
	output logic             pop_valid,
	input  logic             pop_ready,
	output sgrg_pkg::glyph_t pop_item
);

	localparam int PTR_W = $clog2(sgrg_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(sgrg_pkg::QUEUE_DEPTH + 1);

	sgrg_pkg::glyph_t   entry_q [sgrg_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(sgrg_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(sgrg_pkg::QUEUE_DEPTH - 1)) ? '0
				            : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(sgrg_pkg::QUEUE_DEPTH - 1)) ? '0
				            : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: hw/rtl/sgrg_back.sv
// ----------------------------------------------------------------------------
// sgrg_back: scaled row emitter
// Walks the glyph rows at the queue head, one row per cycle when not stalled,
// builds the magnified pixel mask and holds it in the output register.
// ----------------------------------------------------------------------------
module sgrg_back #(
	parameter int MAX_SCALE = 4,
	parameter int SC_W      = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [SC_W-1:0]                     scale,
	input  logic                                head_valid,
	output logic                                head_ready,
	input  sgrg_pkg::glyph_t                    head_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sgrg_pkg::ROW_NUMBER_W-1:0]   out_row,
	output logic [sgrg_pkg::ROW_PIXELS_W-1:0]   out_pixels,
	output logic                                out_last,
	output logic                                out_no_glyph
);

	localparam int RC_W = $clog2(sgrg_pkg::CELL_ROWS * MAX_SCALE);
	localparam int RW   = (RC_W > sgrg_pkg::ROW_NUMBER_W) ? RC_W : sgrg_pkg::ROW_NUMBER_W;
	localparam int PW   = (6 * MAX_SCALE > sgrg_pkg::ROW_PIXELS_W) ? 6 * MAX_SCALE
	                      : sgrg_pkg::ROW_PIXELS_W;
	localparam int IW   = $clog2(PW);

	logic [RW-1:0]                     row_q;
	logic [sgrg_pkg::FONT_ROW_W-1:0]   frow_q;
	logic [SC_W-1:0]                   sub_q;
	logic                              out_valid_q;
	logic [sgrg_pkg::ROW_NUMBER_W-1:0] out_row_q;
	logic [sgrg_pkg::ROW_PIXELS_W-1:0] out_pixels_q;
	logic                              out_last_q;
	logic                              out_no_glyph_q;
	logic                              step;
	logic                              is_last;
	logic [PW-1:0]                     mask;

	assign step       = head_valid && (!out_valid_q || out_ready);
	assign is_last    = (frow_q == sgrg_pkg::FONT_ROW_W'(sgrg_pkg::CELL_ROWS - 1))
	                    && (sub_q == scale - 1'b1);
	assign head_ready = step && is_last;

	assign out_valid    = out_valid_q;
	assign out_row      = out_row_q;
	assign out_pixels   = out_pixels_q;
	assign out_last     = out_last_q;
	assign out_no_glyph = out_no_glyph_q;

	// repeat each lit font pixel scale times; spacing column stays clear
	always_comb begin
		mask = '0;
		for (int c = 0; c < sgrg_pkg::GLYPH_COLUMNS; c++) begin
			for (int k = 0; k < MAX_SCALE; k++) begin
				if (k < int'(scale) && head_item.cols[c][frow_q]) begin
					mask[IW'(c * int'(scale) + k)] = 1'b1;
				end
			end
		end
	end

	// row walk and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			frow_q      <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				if (is_last) begin
					row_q  <= '0;
					frow_q <= '0;
					sub_q  <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					if (sub_q == scale - 1'b1) begin
						sub_q  <= '0;
						frow_q <= frow_q + 1'b1;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (step) begin
			out_row_q      <= row_q[sgrg_pkg::ROW_NUMBER_W-1:0];
			out_pixels_q   <= mask[sgrg_pkg::ROW_PIXELS_W-1:0];
			out_last_q     <= is_last;
			out_no_glyph_q <= head_item.no_glyph;
		end
	end

endmodule

// File: tb/tb_scaled_glyph_row_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scaled_glyph_row_generator: self-checking bench for the glyph row generator
// Sends character codes over the input stream and predicts every scaled pixel
// row from its own copy of the font tables and the scale register. It checks
// each output item against the oldest pending row. It covers code range edges,
// the scale clamps, register writes, several idle and stall mixes, and a long
// output hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_scaled_glyph_row_generator;

	localparam int SCALE_CAP     = 4;
	localparam int CELL_H        = 8;
	localparam int N_COLS        = 5;
	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;
	localparam int BATCH_CODES   = 27;

	// register index past the end of the register list, must be ignored
	localparam logic [sgrg_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	// code ranges with a glyph
	localparam logic [7:0] LATIN_LO   = 8'h20;
	localparam logic [7:0] LATIN_HI   = 8'h7E;
	localparam logic [7:0] CYR_A_LO   = 8'h80;
	localparam logic [7:0] CYR_A_HI   = 8'hAF;
	localparam logic [7:0] CYR_B_LO   = 8'hE0;
	localparam logic [7:0] CYR_B_HI   = 8'hF1;
	localparam logic [7:0] CYR_B_BASE = 8'hB0;

	// glyph columns, column 0 in the top byte, bit r of a column is font row r
	localparam logic [39:0] LATIN_GLYPHS [0:94] = '{
		40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
		40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
		40'h14083e0814, 40'h08083e0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
		40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
		40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324979413e, 40'h7e1111117e, 40'h7f49494936,
		40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
		40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
		40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
		40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
		40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
		40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
		40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
		40'h087e090102, 40'h0c5252523e, 40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
		40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
		40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
		40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
		40'h4464544c44, 40'h0008364100, 40'h00007f0000, 40'h0041360800, 40'h1008081008
	};

	localparam logic [39:0] CYR_GLYPHS [0:65] = '{
		40'h7e1111117e, 40'h7f49494933, 40'h7f49494936, 40'h7f01010103, 40'he0514f41ff,
		40'h7f49494941, 40'h77087f0877, 40'h4149494936, 40'h7f1008047f, 40'h7c2112097c,
		40'h7f08142241, 40'h20413f017f, 40'h7f020c027f, 40'h7f0808087f, 40'h3e4141413e,
		40'h7f0101017f, 40'h7f09090906, 40'h3e41414122, 40'h01017f0101, 40'h4728100807,
		40'h1c227f221c, 40'h6314081463, 40'h7f404040ff, 40'h070808087f, 40'h7f407f407f,
		40'h7f407f40ff, 40'h017f484830, 40'h7f4830007f, 40'h007f484830, 40'h224149493e,
		40'h7f083e413e, 40'h462919097f, 40'h2054545478, 40'h3c4a4a4931, 40'h7c54542800,
		40'h7c0404040c, 40'he0544c44fc, 40'h3854545418, 40'h6c107c106c, 40'h4444545428,
		40'h7c2010087c, 40'h7c4122117c, 40'h7c10284400, 40'h20443c047c, 40'h7c0810087c,
		40'h7c1010107c, 40'h3844444438, 40'h7c0404047c, 40'h7c14141408, 40'h3844444420,
		40'h04047c0404, 40'h0c5050503c, 40'h3048fc4830, 40'h4428102844, 40'h7c404040fc,
		40'h0c1010107c, 40'h7c407c407c, 40'h7c407c40fc, 40'h047c505020, 40'h7c5050207c,
		40'h7c50502000, 40'h2844545438, 40'h7c10384438, 40'h085434147c, 40'h7c55545544,
		40'h3855545518
	};

	typedef struct packed {
		logic [4:0]  row_number;
		logic [23:0] row_pixels;
		logic        last_row;
		logic        no_glyph;
	} pixel_row_t;

	logic                                 clk       = 1'b0;
	logic                                 arst_n    = 1'b0;
	logic                                 s_tvalid  = 1'b0;
	logic                                 s_tready;
	logic [sgrg_pkg::CODE_W-1:0]          s_tdata   = '0;
	logic                                 m_tvalid;
	logic                                 m_tready  = 1'b0;
	logic [sgrg_pkg::TDATA_W-1:0]         m_tdata;
	logic                                 m_tlast;
	logic                                 m_tuser;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [sgrg_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
	logic [sgrg_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

	// shadow registers, written as the block accepts each write
	logic [15:0] fg_shadow    = 16'hFFFF;
	logic [15:0] bg_shadow    = 16'h0000;
	logic [2:0]  scale_shadow = 3'd1;

	pixel_row_t  pending_rows [$];
	int unsigned tx_idle_pct  = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned hold_asks    = 0;
	int unsigned hold_taken   = 0;
	int unsigned hold_left    = 0;
	int unsigned fail_count   = 0;
	int unsigned codes_sent   = 0;
	int unsigned rows_checked = 0;
	int unsigned quiet_cycles = 0;

	scaled_glyph_row_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// rows a character code expands to at the given raw scale setting
	function automatic void expand_glyph_rows(input logic [7:0] code,
		input logic [2:0] scale_raw);
		logic [39:0] glyph;
		logic [7:0]  col_bits;
		logic        blank;
		int          s;
		pixel_row_t  r;
		glyph = '0;
		blank = 1'b0;
		if (code >= LATIN_LO && code <= LATIN_HI) begin
			glyph = LATIN_GLYPHS[code - LATIN_LO];
		end else if (code >= CYR_A_LO && code <= CYR_A_HI) begin
			glyph = CYR_GLYPHS[code - CYR_A_LO];
		end else if (code >= CYR_B_LO && code <= CYR_B_HI) begin
			glyph = CYR_GLYPHS[code - CYR_B_BASE];
		end else begin
			blank = 1'b1;
		end
		// zero acts as one, anything past the cap acts as the cap
		s = (scale_raw == 0) ? 1 : ((scale_raw > SCALE_CAP) ? SCALE_CAP : int'(scale_raw));
		for (int row = 0; row < CELL_H * s; row++) begin
			r.row_number = 5'(row);
			r.row_pixels = '0;
			for (int c = 0; c < N_COLS; c++) begin
				col_bits = glyph[39 - 8 * c -: 8];
				if (col_bits[row / s]) begin
					for (int k = 0; k < s; k++)
						r.row_pixels[c * s + k] = 1'b1;
				end
			end
			r.last_row = (row == CELL_H * s - 1);
			r.no_glyph = blank;
			pending_rows.push_back(r);
		end
	endfunction

	function automatic logic [7:0] pick_code();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 35)
			return 8'($urandom_range(LATIN_LO, LATIN_HI));
		else if (r < 55)
			return 8'($urandom_range(CYR_A_LO, CYR_A_HI));
		else if (r < 65)
			return 8'($urandom_range(CYR_B_LO, CYR_B_HI));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] pick_color();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return 16'h0000;
		else if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic note_failure(input string what, input pixel_row_t want,
		input pixel_row_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%t %s: expected row %0d pix %06h last %b blank %b, %s",
				$realtime, what, want.row_number, want.row_pixels, want.last_row,
				want.no_glyph, $sformatf("got row %0d pix %06h last %b blank %b",
				got.row_number, got.row_pixels, got.last_row, got.no_glyph));
	endtask

	// one code item, with random idle cycles ahead of it
	task automatic send_code(input logic [7:0] code);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic cfg_beat(input logic [sgrg_pkg::CFG_INDEX_W-1:0] idx,
		input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// writes every register plus the unused index, block must be idle
	task automatic write_regs(input logic [15:0] fg, input logic [15:0] bg,
		input logic [2:0] scale);
		cfg_beat(sgrg_pkg::REG_FG_COLOR, fg);
		fg_shadow = fg;
		cfg_beat(sgrg_pkg::REG_BG_COLOR, bg);
		bg_shadow = bg;
		cfg_beat(sgrg_pkg::REG_SCALE, {13'd0, scale});
		scale_shadow = scale;
		cfg_beat(REG_SPARE, 16'($urandom_range(0, 65535)));
		cfg_valid <= 1'b0;
	endtask

	// stop sending and wait for every pending row, then let the pipe empty
	task automatic settle_block();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_code(8'h41);
		send_code(8'h96);
		settle_block();
	endtask

	// range edges, blank codes and a descender glyph at full scale
	task automatic test_glyph_ranges();
		logic [7:0] edges [14] = '{8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'h80, 8'hAF,
			8'hB0, 8'hDF, 8'hE0, 8'hF1, 8'hF2, 8'hFF, 8'h84};
		write_regs(16'hFFFF, 16'h0000, 3'd4);
		foreach (edges[i])
			send_code(edges[i]);
		settle_block();
	endtask

	// zero scale acts as one, large scales clamp to the cap
	task automatic test_scale_clamp();
		write_regs(16'h0000, 16'hFFFF, 3'd0);
		send_code(8'h84);
		send_code(8'h00);
		settle_block();
		write_regs(16'h0000, 16'h0000, 3'd5);
		send_code(8'hA4);
		settle_block();
		write_regs(16'hFFFF, 16'hFFFF, 3'd7);
		send_code(8'hF1);
		settle_block();
	endtask

	// output held off long enough for the input to back up
	task automatic test_full_queue_stall();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		write_regs(pick_color(), pick_color(), 3'd4);
		hold_asks++;
		repeat (12)
			send_code(pick_code());
		settle_block();
	endtask

	task automatic run_traffic_phase(input int unsigned tx_pct, input int unsigned rx_pct,
		input int unsigned batches);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (batches) begin
			write_regs(pick_color(), pick_color(), 3'($urandom_range(0, 7)));
			repeat (BATCH_CODES)
				send_code(pick_code());
			settle_block();
		end
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(0, 0, 3);
		run_traffic_phase(45, 0, 3);
		run_traffic_phase(0, 45, 3);
		run_traffic_phase(21, 21, 3);
	endtask

	// output ready, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_asks != hold_taken) begin
			hold_taken = hold_asks;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// predict rows for each accepted code
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			codes_sent++;
			expand_glyph_rows(s_tdata, scale_shadow);
		end
	end

	// compare each output item with the oldest pending row
	always @(posedge clk) begin
		pixel_row_t got;
		pixel_row_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.row_number = m_tdata[4:0];
			got.row_pixels = m_tdata[28:5];
			got.last_row   = m_tlast;
			got.no_glyph   = m_tuser;
			rows_checked++;
			if (pending_rows.size() == 0) begin
				note_failure("unexpected row", '0, got);
			end else begin
				want = pending_rows.pop_front();
				if (got.row_number != want.row_number || got.row_pixels != want.row_pixels ||
					got.last_row != want.last_row || got.no_glyph != want.no_glyph)
					note_failure("row mismatch", want, got);
			end
		end
	end

	// watchdog on cycles with no item moving anywhere
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_scaled_glyph_row_generator: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_glyph_ranges();
		test_scale_clamp();
		test_full_queue_stall();
		test_random_traffic();
		settle_block();
		$display("run covered %0d codes and %0d rows over scale settings 0 to 7,", codes_sent,
			rows_checked);
		$display("four idle and stall mixes and one full-input stall; %0d mismatches", fail_count);
		if (fail_count == 0 && pending_rows.size() == 0)
			$display("tb_scaled_glyph_row_generator: PASS");
		else
			$display("tb_scaled_glyph_row_generator: FAIL");
		$finish;
	end

endmodule
